FILE: hw/rtl/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and constants of the keyed count table.
// ----------------------------------------------------------------------------
package kct_pkg;

	localparam int ENTRIES  = 16;
	localparam int KEY_BITS = 16;
	localparam int KEY_W    = 16;
	localparam int AMT_W    = 32;
	localparam int COUNT_W  = 31;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SCAN_W   = $clog2(ENTRIES + 1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SET    = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_IGNORED = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]              operation;
		logic [KEY_W-1:0]        key;
		logic signed [AMT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               present;
		status_t            status;
	} rsp_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [COUNT_W-1:0]  count;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic             clr;
		logic [IDX_W-1:0] slot;
		entry_t           data;
	} store_wr_t;

endpackage

FILE: hw/rtl/kct_store.sv
// ----------------------------------------------------------------------------
// kct_store
// Entry memory with one write and one registered read port, plus valid flags.
// ----------------------------------------------------------------------------
module kct_store import kct_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  store_wr_t          wr,
	input  logic [IDX_W-1:0]   rd_addr,
	output entry_t             rd_data,
	output logic [ENTRIES-1:0] valid
);

	entry_t             mem [ENTRIES];
	entry_t             rd_q;
	logic [ENTRIES-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.slot] <= wr.data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.we) begin
			valid_q[wr.slot] <= 1'b1;
		end else if (wr.clr) begin
			valid_q[wr.slot] <= 1'b0;
		end
	end

	assign rd_data = rd_q;
	assign valid   = valid_q;

endmodule

FILE: hw/rtl/kct_unit.sv
// ----------------------------------------------------------------------------
// kct_unit
// Shared key comparator and count adder/subtractor.
// ----------------------------------------------------------------------------
module kct_unit import kct_pkg::*; (
	input  logic [KEY_BITS-1:0] key_a,
	input  logic [KEY_BITS-1:0] key_b,
	input  logic [COUNT_W-1:0]  cnt_a,
	input  logic [COUNT_W-1:0]  cnt_b,
	input  logic                sub,
	output logic                key_eq,
	output logic [COUNT_W:0]    result
);

	assign key_eq = (key_a == key_b);
	assign result = sub ? ({1'b0, cnt_a} - {1'b0, cnt_b})
	                    : ({1'b0, cnt_a} + {1'b0, cnt_b});

endmodule

FILE: hw/rtl/kct_ctrl.sv
// ----------------------------------------------------------------------------
// kct_ctrl
// Request sequencer: for a nonzero key, scans all entries, then applies the operation.
// ----------------------------------------------------------------------------
module kct_ctrl import kct_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  req_t               in_data,
	output logic               res_valid,
	input  logic               res_taken,
	output rsp_t               res_data,
	output store_wr_t          wr,
	output logic [IDX_W-1:0]   rd_addr,
	input  entry_t             rd_data,
	input  logic [ENTRIES-1:0] valid
);

	state_t              state_q;
	state_t              state_d;
	logic [SCAN_W-1:0]   scan_q;
	logic                chk_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                hit_q;
	logic                free_q;
	logic [IDX_W-1:0]    hit_slot_q;
	logic [IDX_W-1:0]    free_slot_q;
	logic [COUNT_W-1:0]  hit_count_q;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [AMT_W-1:0]    amt_q;
	rsp_t                res_q;
	rsp_t                exec_rsp;
	logic                accept;
	logic                key_zero;
	logic                scan_rd;
	logic                scan_last;
	logic                key_eq;
	logic [COUNT_W:0]    alu_res;
	logic                positive;
	logic [COUNT_W-1:0]  amt31;
	logic [COUNT_W-1:0]  sat_sum;
	logic                rem_free;

	kct_unit u_unit (
		.key_a  (rd_data.key),
		.key_b  (key_q),
		.cnt_a  (hit_count_q),
		.cnt_b  (amt31),
		.sub    (op_q == OP_REMOVE),
		.key_eq (key_eq),
		.result (alu_res)
	);

	assign key_zero  = (in_data.key[KEY_BITS-1:0] == '0);
	assign accept    = in_valid && in_ready;
	assign scan_last = (scan_q == SCAN_W'(ENTRIES));
	assign amt31     = amt_q[COUNT_W-1:0];
	assign positive  = !amt_q[AMT_W-1] && (amt_q != '0);
	assign sat_sum   = alu_res[COUNT_W] ? COUNT_MAX : alu_res[COUNT_W-1:0];
	assign rem_free  = alu_res[COUNT_W] || (alu_res[COUNT_W-1:0] == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = key_zero ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_taken) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		res_valid = (state_q == S_DONE);
		scan_rd   = (state_q == S_SCAN) && (scan_q < SCAN_W'(ENTRIES));
		rd_addr   = scan_q[IDX_W-1:0];
		res_data  = res_q;
	end

	always_comb begin
		wr       = '0;
		exec_rsp = '{count: hit_q ? hit_count_q : '0, present: hit_q, status: STAT_DONE};
		if (state_q == S_EXEC) begin
			case (op_t'(op_q))
				OP_ADD: begin
					if (!positive) begin
						exec_rsp.status = STAT_IGNORED;
					end else if (hit_q) begin
						wr.we          = 1'b1;
						wr.slot        = hit_slot_q;
						wr.data        = '{key: key_q, count: sat_sum};
						exec_rsp.count = sat_sum;
					end else if (free_q) begin
						wr.we    = 1'b1;
						wr.slot  = free_slot_q;
						wr.data  = '{key: key_q, count: amt31};
						exec_rsp = '{count: amt31, present: 1'b1, status: STAT_DONE};
					end else begin
						exec_rsp.status = STAT_FULL;
					end
				end
				OP_REMOVE: begin
					if (!positive) begin
						exec_rsp.status = STAT_IGNORED;
					end else if (hit_q && rem_free) begin
						wr.clr   = 1'b1;
						wr.slot  = hit_slot_q;
						exec_rsp = '{count: '0, present: 1'b0, status: STAT_DONE};
					end else if (hit_q) begin
						wr.we          = 1'b1;
						wr.slot        = hit_slot_q;
						wr.data        = '{key: key_q, count: alu_res[COUNT_W-1:0]};
						exec_rsp.count = alu_res[COUNT_W-1:0];
					end
				end
				OP_SET: begin
					if (!positive) begin
						wr.clr   = hit_q;
						wr.slot  = hit_slot_q;
						exec_rsp = '{count: '0, present: 1'b0, status: STAT_DONE};
					end else if (hit_q) begin
						wr.we          = 1'b1;
						wr.slot        = hit_slot_q;
						wr.data        = '{key: key_q, count: amt31};
						exec_rsp.count = amt31;
					end else if (free_q) begin
						wr.we    = 1'b1;
						wr.slot  = free_slot_q;
						wr.data  = '{key: key_q, count: amt31};
						exec_rsp = '{count: amt31, present: 1'b1, status: STAT_DONE};
					end else begin
						exec_rsp.status = STAT_FULL;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= '0;
			chk_s1  <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= scan_rd;
			if (accept) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (state_q == S_SCAN) begin
					scan_q <= scan_q + 1'b1;
				end
				if (chk_s1 && valid[idx_s1] && key_eq) begin
					hit_q <= 1'b1;
				end
				if (chk_s1 && !valid[idx_s1]) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (accept) begin
			op_q  <= in_data.operation;
			key_q <= in_data.key[KEY_BITS-1:0];
			amt_q <= in_data.amount;
			if (key_zero) begin
				res_q <= '{count: '0, present: 1'b0, status: STAT_IGNORED};
			end
		end
		if (chk_s1 && valid[idx_s1] && key_eq && !hit_q) begin
			hit_slot_q  <= idx_s1;
			hit_count_q <= rd_data.count;
		end
		if (chk_s1 && !valid[idx_s1] && !free_q) begin
			free_slot_q <= idx_s1;
		end
		if (state_q == S_EXEC) begin
			res_q <= exec_rsp;
		end
	end

endmodule

FILE: hw/rtl/keyed_count_table_top.sv
// ----------------------------------------------------------------------------
// keyed_count_table_top
// Associative table of key-to-count entries with add, remove, set and query.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready/in_data and results leave on
// out_valid/out_ready/out_data; both channels use a valid/ready handshake.
// Every request produces exactly one result.
// A request with a nonzero key walks the ENTRIES table slots one per cycle
// through the registered read port of the entry memory, then applies the
// operation in the EXEC state and hands the result over in the DONE state.
// A request whose key is zero skips the walk and is answered as ignored.
// The block takes one request at a time; in_ready is low while it works.
// A result waits in the output register while out_ready is low; the next
// request may be taken meanwhile, but its result is held internally until
// the output register frees up.
// Reset clears all slot valid flags at once, and the block is ready as soon
// as reset is released.
// ----------------------------------------------------------------------------
module keyed_count_table_top import kct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);

	store_wr_t          wr;
	logic [IDX_W-1:0]   rd_addr;
	entry_t             rd_data;
	logic [ENTRIES-1:0] valid;
	logic               res_valid;
	logic               res_taken;
	rsp_t               res_data;
	logic               out_valid_q;
	rsp_t               out_data_q;

	kct_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.valid   (valid)
	);

	kct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_taken (res_taken),
		.res_data  (res_data),
		.wr        (wr),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.valid     (valid)
	);

	assign res_taken = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_taken) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_taken) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: hw/rtl/kct_checker.sv
// ----------------------------------------------------------------------------
// kct_port_checks
// Port-level checks of the keyed count table, bound to the top level.
// ----------------------------------------------------------------------------
module kct_port_checks import kct_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input req_t in_data,
	input logic out_valid,
	input logic out_ready,
	input rsp_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Result changed or dropped while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Request taken while the previous one is still in work.");

	a_present_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.present == (out_data.count != '0)))
		else $error("Present flag disagrees with the count.");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STAT_FULL) |-> !out_data.present)
		else $error("Table-full result reports a held key.");

endmodule

bind keyed_count_table_top kct_port_checks u_kct_port_checks (.*);
